// File: rtl/core/bmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and fixed constants of the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int MAX_WINDOW = 15;   // largest odd window side

    localparam int W_PIX  = 16;
    localparam int W_CSUM = 20;
    localparam int W_WSUM = 24;
    localparam int W_WIN  = 4;
    localparam int W_LW   = 13;
    localparam int W_ROW  = 16;
    localparam int W_OCOL = 12;
    localparam int W_NUM  = 26;   // 2*sum + w*w
    localparam int W_DEN  = 9;    // 2*w*w

    localparam logic [1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_WINDOW_SIZE = 2'd1;
    localparam logic [1:0] CFG_WIDE_PIXELS = 2'd2;

    typedef struct packed {
        logic [W_PIX-1:0] pixel;
        logic             frame_start;
    } t_in_item;

    typedef struct packed {
        logic [W_PIX-1:0]  mean_value;
        logic [W_OCOL-1:0] center_col;
        logic [W_ROW-1:0]  center_row;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_SUM,
        S_SUMEND,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// File: rtl/core/bmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/bmf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmf_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [bmf_pkg::W_NUM-1:0] i_num,
    input  logic [bmf_pkg::W_DEN-1:0] i_den,
    output logic                     o_done,
    output logic [bmf_pkg::W_PIX-1:0] o_quot
);
    localparam int CB = $clog2(bmf_pkg::W_NUM);

    logic                      r_busy, r_done;
    logic [CB-1:0]             r_cnt;
    logic [bmf_pkg::W_DEN-1:0] r_rem, r_den;
    logic [bmf_pkg::W_NUM-1:0] r_q;
    logic [bmf_pkg::W_DEN:0]   trial;
    logic                      qbit;

    always_comb begin
        trial = {r_rem, r_q[bmf_pkg::W_NUM-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CB'(bmf_pkg::W_NUM - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? bmf_pkg::W_DEN'(trial - {1'b0, r_den})
                          : trial[bmf_pkg::W_DEN-1:0];
            r_q   <= {r_q[bmf_pkg::W_NUM-2:0], qbit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[bmf_pkg::W_PIX-1:0];
endmodule

// File: rtl/core/box_mean_filter_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_mean_filter_2d
// Rounded mean over an odd square window of a raster pixel stream.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. Its column sum is built from w-1 line
// store reads through the single read port, then the write back. A pixel
// that completes a window also needs w reads of the column sum history RAM
// and a bit-serial divider, with w the effective window size. The output
// register lets the next pixel be taken while a result waits. Register
// writes are taken only while no pixel is in flight. No clearing pass is
// needed after reset.
module box_mean_filter_2d #(
    parameter int MAX_WIDTH  = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bmf_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bmf_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [bmf_pkg::W_LW-1:0]       i_cfg_data
);
    localparam int SL  = bmf_pkg::MAX_WINDOW - 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int SB  = $clog2(SL);
    localparam int LD  = SL * MAX_WIDTH;
    localparam int LA  = $clog2(LD);
    localparam int HB  = $clog2(bmf_pkg::MAX_WINDOW);

    // x mod 15 by folding nibbles (16 is 1 mod 15)
    function automatic logic [HB-1:0] mod15(input logic [15:0] x);
        logic [5:0] s;
        logic [4:0] f;
        s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
        f = 5'(s[5:4]) + 5'(s[3:0]);
        if (f >= 5'd15) f = f - 5'd15;
        return HB'(f);
    endfunction

    // configuration
    logic [bmf_pkg::W_LW-1:0]  r_lw;
    logic [bmf_pkg::W_WIN-1:0] r_ws;
    logic                      r_wide;
    bmf_pkg::t_state           r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw   <= bmf_pkg::W_LW'(4096);
            r_ws   <= bmf_pkg::W_WIN'(3);
            r_wide <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bmf_pkg::CFG_LINE_WIDTH:  r_lw   <= i_cfg_data;
                bmf_pkg::CFG_WINDOW_SIZE: r_ws   <= i_cfg_data[bmf_pkg::W_WIN-1:0];
                bmf_pkg::CFG_WIDE_PIXELS: r_wide <= i_cfg_data[0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = (r_state == bmf_pkg::S_IDLE) && !i_in_valid;

    // effective settings
    logic [31:0]               lw_eff, w32;
    logic [bmf_pkg::W_WIN-1:0] w_eff, half;
    always_comb begin
        lw_eff = 32'(r_lw);
        if (lw_eff == 32'd0) lw_eff = 32'd1;
        if (lw_eff > 32'(MAX_WIDTH)) lw_eff = 32'(MAX_WIDTH);
        w32 = 32'(r_ws);
        if (w32 == 32'd0) w32 = 32'd1;
        if (w32 > 32'(bmf_pkg::MAX_WINDOW)) w32 = 32'(bmf_pkg::MAX_WINDOW);
        if (!w32[0]) w32 = w32 - 32'd1;
        w_eff = w32[bmf_pkg::W_WIN-1:0];
        half  = w_eff >> 1;
    end

    // state
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [bmf_pkg::W_ROW-1:0] r_rowc, n_rowc;
    logic [SB-1:0]             r_slotc, n_slotc;
    logic [bmf_pkg::W_PIX-1:0] r_pix, n_pix;
    logic [CW-1:0]             r_col, n_col;
    logic [bmf_pkg::W_ROW-1:0] r_row, n_row;
    logic [SB-1:0]             r_slot, n_slot;
    logic [SB-1:0]             r_rslot, n_rslot;
    logic [bmf_pkg::W_WIN-1:0] r_k, n_k;
    logic                      r_lpend, n_lpend, r_hpend, n_hpend;
    logic [bmf_pkg::W_CSUM-1:0] r_cacc, n_cacc;
    logic [bmf_pkg::W_WSUM-1:0] r_wacc, n_wacc;
    logic                      r_oval, n_oval;
    bmf_pkg::t_out_item        r_out, n_out;

    // memories
    logic                        l_we, h_we, div_start, div_done;
    logic [LA-1:0]               l_waddr, l_raddr;
    logic [bmf_pkg::W_PIX-1:0]   l_rdata, div_quot;
    logic [HB-1:0]               h_waddr, h_raddr;
    logic [bmf_pkg::W_CSUM-1:0]  h_rdata;
    logic [bmf_pkg::W_NUM-1:0]   div_num;
    logic [bmf_pkg::W_DEN-1:0]   div_den;

    bmf_ram #(.WIDTH(bmf_pkg::W_PIX), .DEPTH(LD)) u_line (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(r_pix),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    bmf_ram #(.WIDTH(bmf_pkg::W_CSUM), .DEPTH(bmf_pkg::MAX_WINDOW)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(n_cacc),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    bmf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmf_pkg::S_IDLE;
            r_cnt   <= '0;
            r_rowc  <= '0;
            r_slotc <= '0;
            r_lpend <= 1'b0;
            r_hpend <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rowc  <= n_rowc;
            r_slotc <= n_slotc;
            r_lpend <= n_lpend;
            r_hpend <= n_hpend;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix   <= n_pix;
        r_col   <= n_col;
        r_row   <= n_row;
        r_slot  <= n_slot;
        r_rslot <= n_rslot;
        r_k     <= n_k;
        r_cacc  <= n_cacc;
        r_wacc  <= n_wacc;
        r_out   <= n_out;
    end

    logic [31:0]               cnt_in, col32, ww32, ws_full;
    logic [SB-1:0]             slot_in;
    logic [bmf_pkg::W_WSUM-1:0] wsum;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rowc  = r_rowc;
        n_slotc = r_slotc;
        n_pix   = r_pix;
        n_col   = r_col;
        n_row   = r_row;
        n_slot  = r_slot;
        n_rslot = r_rslot;
        n_k     = r_k;
        n_lpend = 1'b0;
        n_hpend = 1'b0;
        n_wacc  = r_wacc;
        n_out   = r_out;
        n_oval  = r_oval && i_out_stall;
        n_cacc  = r_cacc + (r_lpend ? bmf_pkg::W_CSUM'(l_rdata) : '0);
        l_we    = 1'b0;
        h_we    = 1'b0;
        div_start = 1'b0;
        l_raddr = LA'(32'(r_rslot) * 32'(MAX_WIDTH) + 32'(r_col));
        l_waddr = LA'(32'(r_slot) * 32'(MAX_WIDTH) + 32'(r_col));
        h_waddr = mod15(16'(r_col));
        h_raddr = mod15(16'(r_col - CW'(r_k)));
        col32   = 32'(r_col);
        ww32    = 32'(w_eff) * 32'(w_eff);
        wsum    = r_wacc + (r_hpend ? bmf_pkg::W_WSUM'(h_rdata) : '0);
        ws_full = 32'(wsum);
        div_num = bmf_pkg::W_NUM'((ws_full << 1) + ww32);
        div_den = bmf_pkg::W_DEN'(ww32 << 1);
        cnt_in  = i_in_data.frame_start ? 32'd0 : 32'(r_cnt);
        slot_in = i_in_data.frame_start ? '0 : r_slotc;
        if (cnt_in >= lw_eff) cnt_in = lw_eff - 32'd1;

        case (r_state)
            bmf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_pix   = r_wide ? i_in_data.pixel
                                     : {8'd0, i_in_data.pixel[7:0]};
                    n_cacc  = bmf_pkg::W_CSUM'(n_pix);
                    n_col   = cnt_in[CW-1:0];
                    n_row   = i_in_data.frame_start ? '0 : r_rowc;
                    n_slot  = slot_in;
                    n_rslot = (slot_in == '0) ? SB'(SL - 1) : slot_in - 1'b1;
                    n_k     = bmf_pkg::W_WIN'(1);
                    n_state = (w_eff == bmf_pkg::W_WIN'(1)) ? bmf_pkg::S_WRITE
                                                            : bmf_pkg::S_READ;
                end
            end
            bmf_pkg::S_READ: begin
                n_lpend = 1'b1;
                n_rslot = (r_rslot == '0) ? SB'(SL - 1) : r_rslot - 1'b1;
                n_k     = r_k + 1'b1;
                if (r_k == w_eff - 1'b1) n_state = bmf_pkg::S_WRITE;
            end
            bmf_pkg::S_WRITE: begin
                l_we = 1'b1;
                h_we = 1'b1;
                if (col32 + 32'd1 >= lw_eff) begin
                    n_cnt   = '0;
                    n_rowc  = (r_row == '1) ? r_row : r_row + 1'b1;
                    n_slotc = (r_slot == SB'(SL - 1)) ? '0 : r_slot + 1'b1;
                end else begin
                    n_cnt   = r_col + 1'b1;
                    n_rowc  = r_row;
                    n_slotc = r_slot;
                end
                n_k    = '0;
                n_wacc = '0;
                if (32'(r_row) + 32'd1 >= 32'(w_eff) && col32 + 32'd1 >= 32'(w_eff))
                    n_state = bmf_pkg::S_SUM;
                else
                    n_state = bmf_pkg::S_IDLE;
            end
            bmf_pkg::S_SUM: begin
                n_hpend = 1'b1;
                n_wacc  = wsum;
                n_k     = r_k + 1'b1;
                if (r_k == w_eff - 1'b1) n_state = bmf_pkg::S_SUMEND;
            end
            bmf_pkg::S_SUMEND: begin
                div_start = 1'b1;
                n_state   = bmf_pkg::S_DIV;
            end
            bmf_pkg::S_DIV: begin
                if (div_done) n_state = bmf_pkg::S_OUT;
            end
            bmf_pkg::S_OUT: begin
                if (!r_oval || !i_out_stall) begin
                    n_out.mean_value = div_quot;
                    n_out.center_col = bmf_pkg::W_OCOL'(col32 - 32'(half));
                    n_out.center_row = r_row - bmf_pkg::W_ROW'(half);
                    n_oval  = 1'b1;
                    n_state = bmf_pkg::S_IDLE;
                end
            end
            default: n_state = bmf_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != bmf_pkg::S_IDLE);
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;
endmodule
